// ===== rtl/core/exptok_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package exptok_pkg;

  typedef enum logic [4:0] {
    TkEq      = 5'd0,
    TkPlus    = 5'd1,
    TkMinus   = 5'd2,
    TkNotEq   = 5'd3,
    TkBang    = 5'd4,
    TkDivide  = 5'd5,
    TkMult    = 5'd6,
    TkLe      = 5'd7,
    TkLt      = 5'd8,
    TkGe      = 5'd9,
    TkGt      = 5'd10,
    TkString  = 5'd11,
    TkLparen  = 5'd12,
    TkRparen  = 5'd13,
    TkAnd     = 5'd14,
    TkOr      = 5'd15,
    TkEof     = 5'd16,
    TkIdent   = 5'd17,
    TkInt     = 5'd18,
    TkIllegal = 5'd19
  } token_kind_e;

  typedef enum logic [2:0] {
    ModeIdle   = 3'd0,
    ModeIdent  = 3'd1,
    ModeNumber = 3'd2,
    ModeString = 3'd3,
    ModeEscape = 3'd4,
    ModeOper   = 3'd5
  } scan_mode_e;

  typedef struct packed {
    token_kind_e kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
  } token_t;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChBang   = 8'h21;
  localparam logic [7:0] ChAmp    = 8'h26;
  localparam logic [7:0] ChQuote  = 8'h27;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChStar   = 8'h2a;
  localparam logic [7:0] ChPlus   = 8'h2b;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChSlash  = 8'h2f;
  localparam logic [7:0] ChLt     = 8'h3c;
  localparam logic [7:0] ChEq     = 8'h3d;
  localparam logic [7:0] ChGt     = 8'h3e;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChUnder  = 8'h5f;
  localparam logic [7:0] ChBar    = 8'h7c;

  localparam logic [15:0] LenMax = 16'hffff;

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || (c == ChUnder);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic token_kind_e single_kind(input logic [7:0] op);
    case (op)
      ChBang:  single_kind = TkBang;
      ChLt:    single_kind = TkLt;
      ChGt:    single_kind = TkGt;
      default: single_kind = TkIllegal;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/expression_tokenizer_unit.sv =====
// An accepted byte is registered, scanned once the token queue has room for two
// tokens, and its tokens are then offered from the four-entry token queue.
// Throughput: one byte per cycle while the token queue has room for two tokens; a
// byte that gives two tokens (flush plus EOF, or a held token plus a single-byte token)
// writes both into the token queue at once, and the queue absorbs the extra token.
// Reset: asynchronous, clears the scanner state, byte position, input valid flag and queue.
`timescale 1ns / 1ps
`default_nettype none

module expression_tokenizer_unit
  import exptok_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  char_code_i,
  input  wire logic        end_of_text_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [4:0]       token_kind_o,
  output logic [15:0]      token_start_o,
  output logic [15:0]      token_length_o,
  output logic             last_of_run_o
);

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  typedef logic [POSITION_BITS-1:0] pos_t;

  logic        in_valid_q;
  logic [7:0]  char_q;
  logic        end_q;

  scan_mode_e  mode_q, mode_d;
  logic [7:0]  held_q, held_d;
  pos_t        lstart_q, lstart_d;
  pos_t        pos_q, pos_d;
  logic [15:0] run_q, run_d;

  token_t      q_q [QDepth];
  logic [PtrW-1:0] head_q, tail_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic        take, proc, pop, is_end;
  logic        h_vld, s_vld;
  token_t      h_tok, s_tok;
  token_t      res [2];
  logic [1:0]  n_res;

  logic        st_emit;
  token_kind_e st_kind;
  scan_mode_e  st_mode;
  logic [15:0] run_inc;

  assign proc       = in_valid_q && (cnt_q <= CntW'(QDepth - 2));
  assign in_stall_o = in_valid_q && !proc;
  assign take       = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign is_end     = end_q || (char_q == ChNul);
  assign run_inc    = (run_q == LenMax) ? run_q : run_q + 16'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      char_q <= char_code_i;
      end_q  <= end_of_text_i;
    end
  end

  // decode of a byte that starts a new token
  always_comb begin
    st_emit = 1'b0;
    st_kind = TkIllegal;
    st_mode = ModeIdle;
    case (char_q) inside
      ChSpace, ChTab, ChLf, ChCr: ;
      ChPlus:   begin st_emit = 1'b1; st_kind = TkPlus;   end
      ChMinus:  begin st_emit = 1'b1; st_kind = TkMinus;  end
      ChSlash:  begin st_emit = 1'b1; st_kind = TkDivide; end
      ChStar:   begin st_emit = 1'b1; st_kind = TkMult;   end
      ChLparen: begin st_emit = 1'b1; st_kind = TkLparen; end
      ChRparen: begin st_emit = 1'b1; st_kind = TkRparen; end
      ChEq, ChBang, ChLt, ChGt, ChAmp, ChBar: st_mode = ModeOper;
      ChQuote:  st_mode = ModeString;
      default: begin
        if (is_letter(char_q)) begin
          st_mode = ModeIdent;
        end else if (is_digit(char_q)) begin
          st_mode = ModeNumber;
        end else begin
          st_emit = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    mode_d   = mode_q;
    held_d   = held_q;
    lstart_d = lstart_q;
    pos_d    = pos_q + pos_t'(1);
    run_d    = run_q;
    h_vld    = 1'b0;
    h_tok    = '{kind: TkIllegal, start: 16'(lstart_q), length: run_q, last: 1'b0};
    s_vld    = 1'b0;
    s_tok    = '{kind: st_kind, start: 16'(pos_q), length: 16'd1, last: 1'b0};

    if (is_end) begin
      case (mode_q)
        ModeOper: begin
          h_vld        = 1'b1;
          h_tok.kind   = single_kind(held_q);
          h_tok.length = 16'd1;
        end
        ModeIdent: begin
          h_vld      = 1'b1;
          h_tok.kind = TkIdent;
        end
        ModeNumber: begin
          h_vld      = 1'b1;
          h_tok.kind = TkInt;
        end
        ModeString, ModeEscape: h_vld = 1'b1;
        default: ;
      endcase
      s_vld        = 1'b1;
      s_tok.kind   = TkEof;
      s_tok.length = 16'd0;
      mode_d       = ModeIdle;
      held_d       = 8'd0;
      lstart_d     = '0;
      pos_d        = '0;
      run_d        = 16'd0;
    end else begin
      case (mode_q)
        ModeOper: begin
          h_vld        = 1'b1;
          h_tok.length = 16'd2;
          mode_d       = ModeIdle;
          case (held_q)
            ChEq:    h_tok.kind = TkEq;
            ChBang:  h_tok.kind = TkNotEq;
            ChLt:    h_tok.kind = TkLe;
            ChGt:    h_tok.kind = TkGe;
            ChAmp:   h_tok.kind = TkAnd;
            default: h_tok.kind = TkOr;
          endcase
          if (!((char_q == ChEq && (held_q == ChEq || held_q == ChBang ||
                                    held_q == ChLt || held_q == ChGt)) ||
                (char_q == ChAmp && held_q == ChAmp) ||
                (char_q == ChBar && held_q == ChBar))) begin
            h_tok.kind   = single_kind(held_q);
            h_tok.length = 16'd1;
            s_vld        = st_emit;
            mode_d       = st_mode;
          end
        end
        ModeIdent, ModeNumber: begin
          if (is_digit(char_q) || (mode_q == ModeIdent && is_letter(char_q))) begin
            run_d = run_inc;
          end else begin
            h_vld      = 1'b1;
            h_tok.kind = (mode_q == ModeIdent) ? TkIdent : TkInt;
            s_vld      = st_emit;
            mode_d     = st_mode;
          end
        end
        ModeString: begin
          if (char_q == ChQuote) begin
            h_vld      = 1'b1;
            h_tok.kind = TkString;
            mode_d     = ModeIdle;
          end else begin
            run_d = run_inc;
            if (char_q == ChBslash) begin
              mode_d = ModeEscape;
            end
          end
        end
        ModeEscape: begin
          run_d  = run_inc;
          mode_d = ModeString;
        end
        default: begin
          s_vld  = st_emit;
          mode_d = st_mode;
        end
      endcase

      // load literal state when a byte opens a new held token
      if ((mode_q == ModeIdle || mode_q == ModeOper || mode_d != mode_q) &&
          !(h_vld && !s_vld && st_mode == ModeIdle
          && mode_q != ModeOper && mode_q != ModeIdent && mode_q != ModeNumber)) begin
        case (mode_d)
          ModeOper: begin
            held_d   = char_q;
            lstart_d = pos_q;
          end
          ModeIdent, ModeNumber: begin
            if (mode_q != ModeIdent && mode_q != ModeNumber || h_vld) begin
              lstart_d = pos_q;
              run_d    = 16'd1;
            end
          end
          ModeString: begin
            if (mode_q != ModeEscape) begin
              lstart_d = pos_q + pos_t'(1);
              run_d    = 16'd0;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    res[0] = h_vld ? h_tok : s_tok;
    res[1] = s_tok;
    n_res  = 2'(h_vld) + 2'(s_vld);
    res[0].last = (n_res == 2'd1);
    res[1].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      held_q   <= 8'd0;
      lstart_q <= '0;
      pos_q    <= '0;
      run_q    <= 16'd0;
    end else if (proc) begin
      mode_q   <= mode_d;
      held_q   <= held_d;
      lstart_q <= lstart_d;
      pos_q    <= pos_d;
      run_q    <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && n_res != 2'd0) begin
      q_q[tail_q] <= res[0];
    end
    if (proc && n_res == 2'd2) begin
      q_q[tail_q + PtrW'(1)] <= res[1];
    end
  end

  assign cnt_d = cnt_q + (proc ? CntW'(n_res) : CntW'(0)) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (proc) begin
        tail_q <= tail_q + PtrW'(n_res);
      end
      if (pop) begin
        head_q <= head_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o    = (cnt_q != '0);
  assign token_kind_o   = q_q[head_q].kind;
  assign token_start_o  = q_q[head_q].start;
  assign token_length_o = q_q[head_q].length;
  assign last_of_run_o  = q_q[head_q].last;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QDepth))
    else $error("token queue count above depth");

  a_pop_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !proc) |=> (cnt_q == $past(cnt_q) - CntW'(1)))
    else $error("token queue count did not drop on transfer");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && is_end) |=> (pos_q == '0 && mode_q == ModeIdle))
    else $error("end of text did not restart the scanner");

  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && is_end) |-> (n_res != 2'd0))
    else $error("end of text produced no token");

endmodule

`default_nettype wire

// ===== sim/expression_tokenizer_checker.sv =====
`timescale 1ns / 1ps

module expression_tokenizer_checker
  import exptok_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  char_code_i,
  input  logic        end_of_text_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [4:0]  token_kind_i,
  input  logic [15:0] token_start_i,
  input  logic [15:0] token_length_i,
  input  logic        last_of_run_i,
  output int          fail_o,
  output int          pending_o
);

  scan_mode_e  mode      = ModeIdle;
  logic [7:0]  held_op   = '0;
  logic [15:0] lit_start = '0;
  logic [15:0] next_pos  = '0;
  logic [15:0] run_len   = '0;

  token_t step_toks[$];
  token_t token_q[$];
  token_t exp_tok;
  int     mismatches  = 0;
  int     outstanding = 0;

  assign fail_o    = mismatches;
  assign pending_o = outstanding;

  function automatic logic char_is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == ChUnder;
  endfunction

  function automatic logic char_is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic token_kind_e lone_kind(input logic [7:0] op);
    case (op)
      ChBang:  return TkBang;
      ChLt:    return TkLt;
      ChGt:    return TkGt;
      default: return TkIllegal;
    endcase
  endfunction

  task automatic push_token(input token_kind_e k, input logic [15:0] s,
                            input logic [15:0] l);
    token_t t;
    t.kind   = k;
    t.start  = s;
    t.length = l;
    t.last   = 1'b0;
    step_toks.push_back(t);
  endtask

  task automatic grow_run();
    if (run_len != LenMax) run_len = run_len + 16'd1;
  endtask

  task automatic open_token(input logic [7:0] c, input logic [15:0] p);
    case (c)
      ChSpace, ChTab, ChLf, ChCr: begin
      end
      ChPlus:   push_token(TkPlus, p, 16'd1);
      ChMinus:  push_token(TkMinus, p, 16'd1);
      ChSlash:  push_token(TkDivide, p, 16'd1);
      ChStar:   push_token(TkMult, p, 16'd1);
      ChLparen: push_token(TkLparen, p, 16'd1);
      ChRparen: push_token(TkRparen, p, 16'd1);
      ChEq, ChBang, ChLt, ChGt, ChAmp, ChBar: begin
        mode      = ModeOper;
        held_op   = c;
        lit_start = p;
      end
      ChQuote: begin
        mode      = ModeString;
        lit_start = p + 16'd1;
        run_len   = '0;
      end
      default: begin
        if (char_is_alpha(c) || char_is_num(c)) begin
          mode      = char_is_alpha(c) ? ModeIdent : ModeNumber;
          lit_start = p;
          run_len   = 16'd1;
        end else begin
          push_token(TkIllegal, p, 16'd1);
        end
      end
    endcase
  endtask

  task automatic scan_byte(input logic [7:0] c, input logic eot);
    logic [15:0] p;
    logic        pair;
    token_kind_e k;
    p = next_pos;
    step_toks.delete();
    if (eot || c == ChNul) begin
      case (mode)
        ModeOper:               push_token(lone_kind(held_op), lit_start, 16'd1);
        ModeIdent:              push_token(TkIdent, lit_start, run_len);
        ModeNumber:             push_token(TkInt, lit_start, run_len);
        ModeString, ModeEscape: push_token(TkIllegal, lit_start, run_len);
        default: begin
        end
      endcase
      push_token(TkEof, p, 16'd0);
      mode      = ModeIdle;
      held_op   = '0;
      lit_start = '0;
      next_pos  = '0;
      run_len   = '0;
    end else begin
      case (mode)
        ModeOper: begin
          pair = 1'b1;
          k    = TkIllegal;
          if (c == ChEq && held_op == ChEq) k = TkEq;
          else if (c == ChEq && held_op == ChBang) k = TkNotEq;
          else if (c == ChEq && held_op == ChLt) k = TkLe;
          else if (c == ChEq && held_op == ChGt) k = TkGe;
          else if (c == ChAmp && held_op == ChAmp) k = TkAnd;
          else if (c == ChBar && held_op == ChBar) k = TkOr;
          else pair = 1'b0;
          mode = ModeIdle;
          if (pair) begin
            push_token(k, lit_start, 16'd2);
          end else begin
            push_token(lone_kind(held_op), lit_start, 16'd1);
            open_token(c, p);
          end
        end
        ModeIdent, ModeNumber: begin
          if (char_is_num(c) || (mode == ModeIdent && char_is_alpha(c))) begin
            grow_run();
          end else begin
            push_token(mode == ModeIdent ? TkIdent : TkInt, lit_start, run_len);
            mode = ModeIdle;
            open_token(c, p);
          end
        end
        ModeString: begin
          if (c == ChQuote) begin
            push_token(TkString, lit_start, run_len);
            mode = ModeIdle;
          end else begin
            grow_run();
            if (c == ChBslash) mode = ModeEscape;
          end
        end
        ModeEscape: begin
          grow_run();
          mode = ModeString;
        end
        default: open_token(c, p);
      endcase
      next_pos = p + 16'd1;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last = 1'b1;
    foreach (step_toks[i]) token_q.push_back(step_toks[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode      = ModeIdle;
      held_op   = '0;
      lit_start = '0;
      next_pos  = '0;
      run_len   = '0;
      token_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) scan_byte(char_code_i, end_of_text_i);
      if (out_valid_i && !out_stall_i) begin
        if (token_q.size() == 0) begin
          $error("unexpected token: kind %0d start %0d length %0d",
                 token_kind_i, token_start_i, token_length_i);
          mismatches++;
        end else begin
          exp_tok = token_q.pop_front();
          if (token_kind_i !== exp_tok.kind) begin
            $error("token_kind: expected %0d, actual %0d", exp_tok.kind, token_kind_i);
            mismatches++;
          end
          if (token_start_i !== exp_tok.start) begin
            $error("token_start: expected %0d, actual %0d", exp_tok.start, token_start_i);
            mismatches++;
          end
          if (token_length_i !== exp_tok.length) begin
            $error("token_length: expected %0d, actual %0d", exp_tok.length,
                   token_length_i);
            mismatches++;
          end
          if (last_of_run_i !== exp_tok.last) begin
            $error("last_of_run: expected %0d, actual %0d", exp_tok.last, last_of_run_i);
            mismatches++;
          end
        end
      end
    end
    outstanding = token_q.size();
  end

endmodule

// ===== sim/expression_tokenizer_unit_tb.sv =====
`timescale 1ns / 1ps

module expression_tokenizer_unit_tb;
  import exptok_pkg::*;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic [7:0]  char_code   = '0;
  logic        end_of_text = 1'b0;
  logic        out_stall   = 1'b0;
  logic        gaps_on     = 1'b1;
  wire         in_stall;
  wire         out_valid;
  wire  [4:0]  token_kind;
  wire  [15:0] token_start;
  wire  [15:0] token_length;
  wire         last_of_run;
  int          fail_count;
  int          pending;
  int          bytes_sent = 0;

  localparam string Letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
  localparam string Alnum   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
  localparam string Digits  = "0123456789";
  localparam string OpChars = "=!<>&|+-*/()";
  localparam string Blanks  = " \t\n\r";

  expression_tokenizer_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .char_code_i    (char_code),
    .end_of_text_i  (end_of_text),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .token_kind_o   (token_kind),
    .token_start_o  (token_start),
    .token_length_o (token_length),
    .last_of_run_o  (last_of_run)
  );

  expression_tokenizer_checker u_chk (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .char_code_i    (char_code),
    .end_of_text_i  (end_of_text),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .token_kind_i   (token_kind),
    .token_start_i  (token_start),
    .token_length_i (token_length),
    .last_of_run_i  (last_of_run),
    .fail_o         (fail_count),
    .pending_o      (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 21);
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [7:0] pick_char(input string s);
    return s[$urandom_range(s.len() - 1)];
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic eot);
    while (gaps_on && $urandom_range(99) < 21) begin
      in_valid  = 1'b0;
      char_code = 8'($urandom_range(255));
      @(negedge clk);
    end
    in_valid    = 1'b1;
    char_code   = c;
    end_of_text = eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_random_token();
    int sel;
    int n;
    logic [7:0] op;
    sel = $urandom_range(99);
    if (sel < 25) begin
      send_byte(pick_char(Letters), 1'b0);
      n = $urandom_range(6);
      repeat (n) send_byte(pick_char(Alnum), 1'b0);
    end else if (sel < 40) begin
      n = $urandom_range(1, 5);
      repeat (n) send_byte(pick_char(Digits), 1'b0);
    end else if (sel < 52) begin
      send_byte(ChQuote, 1'b0);
      n = $urandom_range(6);
      repeat (n) begin
        if ($urandom_range(4) == 0) begin
          send_byte(ChBslash, 1'b0);
          send_byte(8'($urandom_range(1, 255)), 1'b0);
        end else begin
          op = 8'($urandom_range(1, 255));
          send_byte(op == ChQuote ? "q" : op, 1'b0);
        end
      end
      if ($urandom_range(9) != 0) send_byte(ChQuote, 1'b0);
    end else if (sel < 80) begin
      op = pick_char(OpChars);
      send_byte(op, 1'b0);
      case ($urandom_range(3))
        0: send_byte(ChEq, 1'b0);
        1: send_byte(op, 1'b0);
        default: begin
        end
      endcase
    end else if (sel < 88) begin
      send_byte(pick_char(Blanks), 1'b0);
    end else if (sel < 94) begin
      send_byte(8'($urandom_range(1, 255)), 1'b0);
    end else if (sel < 98) begin
      if ($urandom_range(1)) send_byte(8'($urandom_range(255)), 1'b1);
      else send_byte(ChNul, 1'b0);
    end else begin
      send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_text("_9 7'\\''!<>=(==!=<=&&||)&|=+-*/>");
    send_byte(8'h41, 1'b1);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_text("\t'a\\");
    send_byte(ChNul, 1'b0);
    in_valid = 1'b0;

    wait_drained();

    while (bytes_sent < 400) send_random_token();
    gaps_on = 1'b0;
    while (bytes_sent < 550) send_random_token();
    gaps_on = 1'b1;
    while (bytes_sent < 690) send_random_token();
    send_byte(8'h00, 1'b1);
    in_valid = 1'b0;

    wait_drained();
    repeat (12) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== expression_tokenizer_unit.f =====
rtl/core/exptok_pkg.sv
rtl/core/expression_tokenizer_unit.sv
sim/expression_tokenizer_checker.sv
sim/expression_tokenizer_unit_tb.sv
